[rtl/jitc_pkg.sv]
package jitc_pkg;

  localparam int DATA_W     = 32;
  localparam int ERR_W      = 33;
  localparam int ACC_W      = 52;
  localparam int DIFF_W     = 42;
  localparam int MUL_A_W    = 18;
  localparam int MUL_B_W    = 33;
  localparam int PROD_W     = 51;
  localparam int GAIN_W     = 9;
  localparam int GAIN_REG_W = 63;
  localparam int ALPHA_W    = 17;
  localparam int LIMIT_W    = 31;
  localparam int JOINT_W    = 3;
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int FILT_SHIFT = 16;
  localparam int TQ_SHIFT   = 12;

  localparam logic [ALPHA_W-1:0]    ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0]    ALPHA_RST   = 17'd6554;
  localparam logic [LIMIT_W-1:0]    STEP_RST    = 31'd3355443;
  localparam logic [LIMIT_W-1:0]    TCHG_RST    = 31'd65536;
  localparam logic [GAIN_REG_W-1:0] KGAIN_RST   = 63'd362052706524277910;
  localparam logic [GAIN_REG_W-1:0] DGAIN_RST   = 63'd867514706590556400;

  localparam logic signed [ACC_W-1:0] FILT_ROUND = 52'sd32768;
  localparam logic signed [ACC_W-1:0] TQ_ROUND   = 52'sd2048;
  localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(33'sh1_8000_0000);

  typedef enum logic [1:0] {
    KIND_TORQUE = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_ALPHA = 3'd0,
    REG_STEP  = 3'd1,
    REG_TCHG  = 3'd2,
    REG_KGAIN = 3'd3,
    REG_DGAIN = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_F1,
    S_F2,
    S_F3,
    S_T1,
    S_T2,
    S_T3,
    S_T4,
    S_CHK_RD,
    S_CHK_EV,
    S_CPY_RD,
    S_CPY_WR,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] des;
    logic [DATA_W-1:0] meas;
    logic [DATA_W-1:0] fv;
    logic [DATA_W-1:0] lt;
  } joint_word_t;

endpackage

[rtl/jitc_if.sv]
interface jitc_in_if
  import jitc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [JOINT_W-1:0]       joint;
  logic                     last;
  logic signed [DATA_W-1:0] position;
  logic signed [DATA_W-1:0] velocity;
  logic signed [DATA_W-1:0] coriolis;

  modport source (output valid, mode, joint, last, position, velocity, coriolis, input ready);
  modport sink (input valid, mode, joint, last, position, velocity, coriolis, output ready);
endinterface

interface jitc_out_if
  import jitc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic [JOINT_W-1:0]       joint_out;
  logic signed [DATA_W-1:0] torque;

  modport source (output valid, kind, joint_out, torque, input ready);
  modport sink (input valid, kind, joint_out, torque, output ready);
endinterface

[rtl/jitc_ram.sv]
module jitc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/joint_impedance_torque_controller.sv]
// joint impedance torque controller
// in_if carries joint items. mode 1 is a measurement sample for one joint; for a
// joint in range the block filters its velocity, forms stiffness and damping torque
// plus coriolis, slew limits against the last command and returns one torque result.
// mode 0 items stage a target position per joint; the item marked last returns
// one accept or reject result. out_if carries the results; the APB port holds
// the filter weight, step limit, torque slew limit and the packed gains.
// a sample runs from its transfer through one read of the joint memory, a shared
// 18x33 multiplier used four times in sequence, then the slew clamp, the write back
// and the load of the result register. in_if.ready is high only between items.
// a target element not marked last gives no result. a final element of a
// complete set runs a read/compare pass and then a copy pass over the joint memory,
// with a read and an evaluate or write state per joint; a failed compare ends early.
// a result waits in the output register while the receiver stalls; the next
// item is still taken, and a later result waits until the register is free.
// reset clears all joint state, staging and the started flags, and loads the
// register reset values; no clearing pass is needed.
module joint_impedance_torque_controller
  import jitc_pkg::*;
#(
  parameter int JOINTS = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  jitc_in_if.sink               in_if,
  jitc_out_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);
  localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int JXW    = JW + JOINT_W;
  localparam int WORD_W = $bits(joint_word_t);
  localparam logic [JOINTS-1:0] ALL_MASK = {JOINTS{1'b1}};
  localparam logic [JXW-1:0]    JOINTS_X = JXW'(JOINTS);
  localparam logic [JW-1:0]     LAST_IDX = JW'(JOINTS - 1);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [ALPHA_W-1:0]    alpha_r;
  logic [LIMIT_W-1:0]    step_r;
  logic [LIMIT_W-1:0]    tchg_r;
  logic [GAIN_REG_W-1:0] kgain_r;
  logic [GAIN_REG_W-1:0] dgain_r;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      step_r  <= STEP_RST;
      tchg_r  <= TCHG_RST;
      kgain_r <= KGAIN_RST;
      dgain_r <= DGAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALPHA: alpha_r <= pwdata[ALPHA_W-1:0];
        REG_STEP:  step_r  <= pwdata[LIMIT_W-1:0];
        REG_TCHG:  tchg_r  <= pwdata[LIMIT_W-1:0];
        REG_KGAIN: kgain_r <= pwdata[GAIN_REG_W-1:0];
        REG_DGAIN: dgain_r <= pwdata[GAIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHA: prdata = APB_DATA_W'(alpha_r);
      REG_STEP:  prdata = APB_DATA_W'(step_r);
      REG_TCHG:  prdata = APB_DATA_W'(tchg_r);
      REG_KGAIN: prdata = APB_DATA_W'(kgain_r);
      REG_DGAIN: prdata = APB_DATA_W'(dgain_r);
      default:   prdata = '0;
    endcase
  end

  // control and datapath registers
  state_t                   state_r, state_nxt;
  logic [JW-1:0]            addr_r, addr_nxt;
  logic [JOINT_W-1:0]       jr_r, jr_nxt;
  logic signed [DATA_W-1:0] pos_r, pos_nxt;
  logic signed [DATA_W-1:0] vel_r, vel_nxt;
  logic signed [DATA_W-1:0] cor_r, cor_nxt;
  logic signed [DATA_W-1:0] des_r, des_nxt;
  logic signed [DATA_W-1:0] fv_r, fv_nxt;
  logic signed [DATA_W-1:0] lt_r, lt_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [DIFF_W-1:0] dc_r, dc_nxt;
  kind_t                    reply_kind_r, reply_kind_nxt;
  logic [JOINTS-1:0]        joint_started_r, joint_started_nxt;
  logic [JOINTS-1:0]        staged_seen_r, staged_seen_nxt;
  logic                     staged_bad_r, staged_bad_nxt;
  logic [JOINTS-1:0]        a_valid_r, a_valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  kind_t                    out_kind_r, out_kind_nxt;
  logic [JOINT_W-1:0]       out_joint_r, out_joint_nxt;
  logic signed [DATA_W-1:0] out_torque_r, out_torque_nxt;

  // input decode
  logic [JXW-1:0] in_jx;
  logic [JW-1:0]  in_jidx;
  logic           in_jok;
  logic           in_acc;
  logic           slot_free;

  assign in_jx       = JXW'(in_if.joint);
  assign in_jidx     = in_jx[JW-1:0];
  assign in_jok      = in_jx < JOINTS_X;
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign slot_free   = !out_valid_r || out_if.ready;

  assign out_if.valid     = out_valid_r;
  assign out_if.kind      = out_kind_r;
  assign out_if.joint_out = out_joint_r;
  assign out_if.torque    = out_torque_r;

  // joint state memory and staged target memory
  logic              a_we;
  joint_word_t       a_wdata;
  logic [WORD_W-1:0] a_rdata;
  joint_word_t       a_word;
  logic              b_we;
  logic [DATA_W-1:0] b_rdata;
  logic [JW-1:0]     raddr;

  assign raddr  = (state_r == S_IDLE) ? in_jidx : addr_r;
  assign a_word = a_valid_r[addr_r] ? joint_word_t'(a_rdata) : '0;

  jitc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (JOINTS)
  ) u_joint_mem (
    .clk   (clk),
    .we    (a_we),
    .waddr (addr_r),
    .wdata (a_wdata),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  jitc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (JOINTS)
  ) u_target_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_jidx),
    .wdata (in_if.position),
    .raddr (raddr),
    .rdata (b_rdata)
  );

  // gains and limits
  logic [GAIN_REG_W+GAIN_W-1:0] kg_ext, dg_ext;
  logic [6:0]                   gsh;
  logic [GAIN_W-1:0]            kg, dg;
  logic [ALPHA_W-1:0]           alpha_eff, alpha_om;
  logic signed [DIFF_W-1:0]     lim_x;
  logic signed [ERR_W-1:0]      step_x;

  assign kg_ext    = {{GAIN_W{1'b0}}, kgain_r};
  assign dg_ext    = {{GAIN_W{1'b0}}, dgain_r};
  assign gsh       = 7'(jr_r) * 7'd9;
  assign kg        = kg_ext[gsh +: GAIN_W];
  assign dg        = dg_ext[gsh +: GAIN_W];
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign alpha_om  = ALPHA_ONE - alpha_eff;
  assign lim_x     = $signed(DIFF_W'(tchg_r));
  assign step_x    = $signed(ERR_W'(step_r));

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_x;

  always_comb begin
    unique case (state_r)
      S_F1: begin
        mul_a = $signed({1'b0, alpha_om});
        mul_b = MUL_B_W'(fv_r);
      end
      S_F2: begin
        mul_a = $signed({1'b0, alpha_eff});
        mul_b = MUL_B_W'(vel_r);
      end
      S_F3: begin
        mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, kg});
        mul_b = err_r;
      end
      default: begin
        mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, dg});
        mul_b = MUL_B_W'(fv_r);
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_x = ACC_W'(prod);

  // sequencer
  logic signed [DATA_W-1:0] des_new;
  logic signed [ERR_W-1:0]  chk_d;
  logic signed [DATA_W-1:0] tq;
  logic [JOINTS-1:0]        seen_v;
  logic                     bad_v;

  assign des_new = joint_started_r[addr_r] ? $signed(a_word.des) : pos_r;
  assign chk_d   = ERR_W'($signed(b_rdata)) - ERR_W'($signed(a_word.meas));
  assign tq      = sat32(ACC_W'(lt_r) + ACC_W'(dc_r));

  always_comb begin
    state_nxt         = state_r;
    addr_nxt          = addr_r;
    jr_nxt            = jr_r;
    pos_nxt           = pos_r;
    vel_nxt           = vel_r;
    cor_nxt           = cor_r;
    des_nxt           = des_r;
    fv_nxt            = fv_r;
    lt_nxt            = lt_r;
    err_nxt           = err_r;
    acc_nxt           = acc_r;
    diff_nxt          = diff_r;
    dc_nxt            = dc_r;
    reply_kind_nxt    = reply_kind_r;
    joint_started_nxt = joint_started_r;
    staged_seen_nxt   = staged_seen_r;
    staged_bad_nxt    = staged_bad_r;
    a_valid_nxt       = a_valid_r;
    out_valid_nxt     = out_valid_r && !out_if.ready;
    out_kind_nxt      = out_kind_r;
    out_joint_nxt     = out_joint_r;
    out_torque_nxt    = out_torque_r;
    a_we              = 1'b0;
    a_wdata           = a_word;
    b_we              = 1'b0;
    seen_v            = staged_seen_r;
    bad_v             = staged_bad_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          jr_nxt   = in_if.joint;
          pos_nxt  = in_if.position;
          vel_nxt  = in_if.velocity;
          cor_nxt  = in_if.coriolis;
          addr_nxt = in_jidx;
          if (in_if.mode) begin
            if (in_jok) begin
              state_nxt = S_LOAD;
            end
          end else begin
            if (in_jok) begin
              b_we   = 1'b1;
              seen_v = staged_seen_r | (JOINTS'(1) << in_jidx);
            end else begin
              bad_v = 1'b1;
            end
            staged_seen_nxt = seen_v;
            staged_bad_nxt  = bad_v;
            if (in_if.last) begin
              addr_nxt = '0;
              if (seen_v == ALL_MASK && !bad_v) begin
                state_nxt = S_CHK_RD;
              end else begin
                reply_kind_nxt = KIND_REJECT;
                state_nxt      = S_REPLY;
              end
            end
          end
        end
      end
      S_LOAD: begin
        des_nxt = des_new;
        fv_nxt  = $signed(a_word.fv);
        lt_nxt  = $signed(a_word.lt);
        err_nxt = ERR_W'(des_new) - ERR_W'(pos_r);
        joint_started_nxt[addr_r] = 1'b1;
        state_nxt = S_F1;
      end
      S_F1: begin
        acc_nxt   = prod_x + FILT_ROUND;
        state_nxt = S_F2;
      end
      S_F2: begin
        acc_nxt   = acc_r + prod_x;
        state_nxt = S_F3;
      end
      S_F3: begin
        fv_nxt    = sat32(acc_r >>> FILT_SHIFT);
        acc_nxt   = (prod_x <<< 4) + (ACC_W'(cor_r) <<< TQ_SHIFT) + TQ_ROUND;
        state_nxt = S_T1;
      end
      S_T1: begin
        acc_nxt   = acc_r - prod_x;
        state_nxt = S_T2;
      end
      S_T2: begin
        diff_nxt  = DIFF_W'(acc_r >>> TQ_SHIFT) - DIFF_W'(lt_r);
        state_nxt = S_T3;
      end
      S_T3: begin
        priority if (diff_r > lim_x) begin
          dc_nxt = lim_x;
        end else if (diff_r < -lim_x) begin
          dc_nxt = -lim_x;
        end else begin
          dc_nxt = diff_r;
        end
        state_nxt = S_T4;
      end
      S_T4: begin
        if (slot_free) begin
          a_we                = 1'b1;
          a_wdata             = {des_r, pos_r, fv_r, tq};
          a_valid_nxt[addr_r] = 1'b1;
          out_valid_nxt       = 1'b1;
          out_kind_nxt        = KIND_TORQUE;
          out_joint_nxt       = jr_r;
          out_torque_nxt      = tq;
          state_nxt           = S_IDLE;
        end
      end
      S_CHK_RD: begin
        state_nxt = S_CHK_EV;
      end
      S_CHK_EV: begin
        priority if (chk_d > step_x || chk_d < -step_x) begin
          reply_kind_nxt = KIND_REJECT;
          state_nxt      = S_REPLY;
        end else if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = S_CPY_RD;
        end else begin
          addr_nxt  = addr_r + JW'(1);
          state_nxt = S_CHK_RD;
        end
      end
      S_CPY_RD: begin
        state_nxt = S_CPY_WR;
      end
      S_CPY_WR: begin
        a_we                = 1'b1;
        a_wdata.des         = b_rdata;
        a_valid_nxt[addr_r] = 1'b1;
        if (addr_r == LAST_IDX) begin
          reply_kind_nxt = KIND_ACCEPT;
          state_nxt      = S_REPLY;
        end else begin
          addr_nxt  = addr_r + JW'(1);
          state_nxt = S_CPY_RD;
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = reply_kind_r;
          out_joint_nxt   = '0;
          out_torque_nxt  = '0;
          staged_seen_nxt = '0;
          staged_bad_nxt  = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      joint_started_r <= '0;
      staged_seen_r   <= '0;
      staged_bad_r    <= 1'b0;
      a_valid_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      joint_started_r <= joint_started_nxt;
      staged_seen_r   <= staged_seen_nxt;
      staged_bad_r    <= staged_bad_nxt;
      a_valid_r       <= a_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    jr_r         <= jr_nxt;
    pos_r        <= pos_nxt;
    vel_r        <= vel_nxt;
    cor_r        <= cor_nxt;
    des_r        <= des_nxt;
    fv_r         <= fv_nxt;
    lt_r         <= lt_nxt;
    err_r        <= err_nxt;
    acc_r        <= acc_nxt;
    diff_r       <= diff_nxt;
    dc_r         <= dc_nxt;
    reply_kind_r <= reply_kind_nxt;
    out_kind_r   <= out_kind_nxt;
    out_joint_r  <= out_joint_nxt;
    out_torque_r <= out_torque_nxt;
  end

  // checks
  a_torque_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T4 && slot_free) |=>
      (out_if.valid && out_if.kind == KIND_TORQUE && out_if.joint_out == $past(jr_r)))
    else $error("torque result not loaded after write back");

  a_slew_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T4) |-> (dc_r <= lim_x && dc_r >= -lim_x))
    else $error("torque step outside slew limit");

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ((joint_started_r & $past(joint_started_r)) == $past(joint_started_r)))
    else $error("joint started flag cleared");

  a_copy_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CPY_WR) |-> (staged_seen_r == ALL_MASK && !staged_bad_r))
    else $error("target copied from incomplete set");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
  import jitc_pkg::*;
();

  localparam int     NJ            = 7;
  localparam int     SETTLE_CYCLES = 64;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     PHASE_ITEMS   = 100;
  localparam int     PHASES        = 6;
  localparam longint CYCLE_LIMIT   = 400000;
  localparam longint S32_MAX       = 64'sd2147483647;
  localparam longint S32_MIN       = -64'sd2147483648;

  typedef struct packed {
    logic               mode;
    logic [2:0]         jnt;
    logic               last;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] cor;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         jnt;
    logic signed [31:0] tq;
  } reply_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   fixed;
    reply_t reply;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  jitc_in_if  in_if ();
  jitc_out_if out_if ();

  joint_impedance_torque_controller #(
    .JOINTS(NJ)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0]    jp_meas    [NJ];
  logic signed [31:0]    jp_goal    [NJ];
  logic signed [31:0]    jv_filt    [NJ];
  logic signed [31:0]    jt_prev    [NJ];
  logic signed [31:0]    goal_stage [NJ];
  logic [NJ-1:0]         live_mask;
  logic [NJ-1:0]         stage_mask;
  logic                  stage_broken;
  logic [ALPHA_W-1:0]    cf_alpha;
  logic [LIMIT_W-1:0]    cf_step;
  logic [LIMIT_W-1:0]    cf_tchg;
  logic [GAIN_REG_W-1:0] cf_kgain;
  logic [GAIN_REG_W-1:0] cf_dgain;

  reply_t torque_replies_q [$];
  int     errors        = 0;
  int     cfg_errors    = 0;
  int     n_torque      = 0;
  int     n_accept      = 0;
  int     n_reject      = 0;
  int     src_idle_pct  = 0;
  int     rcv_stall_pct = 0;
  bit     hold_req      = 1'b0;
  int     hold_left     = 0;
  longint cycle_count   = 0;

  plan_row_t directed_plan [25] = '{
    '{'{1'b1, 3'd0, 1'b0, 32'sh7FFF_FFFF, 32'sd0, 32'sd0}, 1'b1,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b1, 3'd1, 1'b0, 32'sh8000_0000, 32'sd0, 32'sh7FFF_FFFF}, 1'b1,
      '{KIND_TORQUE, 3'd1, 32'sd65536}},
    '{'{1'b1, 3'd2, 1'b0, 32'sd0, 32'sd0, 32'sh8000_0000}, 1'b1,
      '{KIND_TORQUE, 3'd2, -32'sd65536}},
    '{'{1'b1, 3'd7, 1'b0, 32'sh1234_5678, 32'sh0100_0000, 32'sh0001_0000}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b1, 3'd3, 1'b0, 32'sd0, 32'sh7FFF_FFFF, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b1, 3'd4, 1'b1, 32'sh0100_0000, 32'sh8000_0000, 32'sh0003_0000}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    // lone final element, set incomplete
    '{'{1'b0, 3'd0, 1'b1, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
      '{KIND_REJECT, 3'd0, 32'sd0}},
    // full set poisoned by an out of range joint
    '{'{1'b0, 3'd7, 1'b0, 32'sd0, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd0, 1'b0, 32'sh7FFF_FFFF, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd1, 1'b0, 32'sh8000_0000, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd2, 1'b0, 32'sd0, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd3, 1'b0, 32'sd0, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd4, 1'b0, 32'sh0100_0000, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd5, 1'b0, 32'sd0, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd6, 1'b1, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
      '{KIND_REJECT, 3'd0, 32'sd0}},
    // full set at the step limit, accepted
    '{'{1'b0, 3'd0, 1'b0, 32'sh7FFF_FFFF, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd1, 1'b0, 32'sh8000_0000, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd2, 1'b0, 32'sd0, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd3, 1'b0, 32'sd3355443, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd4, 1'b0, 32'sh0100_0000, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd5, 1'b0, -32'sd3355443, 32'sd0, 32'sd0}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b0, 3'd6, 1'b1, 32'sd1000, 32'sd0, 32'sd0}, 1'b1,
      '{KIND_ACCEPT, 3'd0, 32'sd0}},
    // first sample overrides the accepted target
    '{'{1'b1, 3'd5, 1'b0, 32'sd12345, 32'sd0, 32'sd0}, 1'b1,
      '{KIND_TORQUE, 3'd5, 32'sd0}},
    '{'{1'b1, 3'd3, 1'b0, 32'sd0, 32'sh00AB_CDEF, 32'shFFF0_0000}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}},
    '{'{1'b1, 3'd6, 1'b0, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'sd1}, 1'b0,
      '{KIND_TORQUE, 3'd0, 32'sd0}}
  };

  function automatic longint clip32(input longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic bit impedance_step(input cmd_t c, output reply_t r);
    longint      a;
    longint      fv;
    longint      err;
    longint      acc;
    longint      tq;
    longint      diff;
    longint      lim;
    longint      gap;
    longint      kgain;
    longint      dgain;
    int unsigned j;
    int          k;
    bit          ok;
    j = c.jnt;
    r = '{KIND_TORQUE, 3'd0, 32'sd0};
    if (c.mode) begin
      if (j >= NJ) return 1'b0;
      if (!live_mask[j]) begin
        jp_goal[j] = c.pos;
        live_mask[j] = 1'b1;
      end
      jp_meas[j] = c.pos;
      a = (cf_alpha > ALPHA_ONE) ? 64'sd65536 : longint'(cf_alpha);
      fv = ((64'sd65536 - a) * longint'(jv_filt[j]) + a * longint'(c.vel) + 64'sd32768) >>> 16;
      jv_filt[j] = 32'(clip32(fv));
      kgain = longint'(cf_kgain[9*j +: 9]);
      dgain = longint'(cf_dgain[9*j +: 9]);
      err = longint'(jp_goal[j]) - longint'(jp_meas[j]);
      acc = kgain * err * 16 - dgain * longint'(jv_filt[j]) + longint'(c.cor) * 4096;
      tq = (acc + 64'sd2048) >>> 12;
      lim = longint'(cf_tchg);
      diff = tq - longint'(jt_prev[j]);
      if (diff > lim) diff = lim;
      if (diff < -lim) diff = -lim;
      tq = clip32(longint'(jt_prev[j]) + diff);
      jt_prev[j] = 32'(tq);
      r.jnt = c.jnt;
      r.tq = 32'(tq);
      return 1'b1;
    end
    if (j < NJ) begin
      goal_stage[j] = c.pos;
      stage_mask[j] = 1'b1;
    end else begin
      stage_broken = 1'b1;
    end
    if (!c.last) return 1'b0;
    ok = (stage_mask == '1) && !stage_broken;
    for (k = 0; k < NJ; k++) begin
      gap = longint'(goal_stage[k]) - longint'(jp_meas[k]);
      if (gap < 0) gap = -gap;
      if (ok && gap > longint'(cf_step)) ok = 1'b0;
    end
    if (ok) begin
      for (k = 0; k < NJ; k++) jp_goal[k] = goal_stage[k];
    end
    stage_mask = '0;
    stage_broken = 1'b0;
    r.kind = ok ? KIND_ACCEPT : KIND_REJECT;
    return 1'b1;
  endfunction

  function automatic int pick_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return int'($urandom_range(1 << 20)) - (1 << 19);
    endcase
  endfunction

  // target near the stored measurement, now and then just past the step limit
  function automatic logic signed [31:0] near_target(input int unsigned jj);
    longint d;
    case ($urandom_range(49))
      0: d = longint'(cf_step) + 1;
      1: d = longint'(cf_step);
      2: d = -longint'(cf_step);
      default: begin
        d = longint'($urandom) % (longint'(cf_step) + 1);
        if ($urandom_range(1)) d = -d;
      end
    endcase
    return 32'(longint'(jp_meas[jj]) + d);
  endfunction

  task automatic push_item(input cmd_t c, input bit fixed, input reply_t want);
    reply_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.mode     <= c.mode;
    in_if.joint    <= c.jnt;
    in_if.last     <= c.last;
    in_if.position <= c.pos;
    in_if.velocity <= c.vel;
    in_if.coriolis <= c.cor;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (impedance_step(c, r))
      torque_replies_q.insert(torque_replies_q.size(), fixed ? want : r);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    logic [63:0] held;
    case (idx)
      REG_ALPHA:          held = 64'(value[ALPHA_W-1:0]);
      REG_STEP, REG_TCHG: held = 64'(value[LIMIT_W-1:0]);
      default:            held = 64'(value[GAIN_REG_W-1:0]);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== held) begin
      cfg_errors++;
      $display("%0t: register %s readback, expected %h got %h", $time, idx.name(), held,
               prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ALPHA: cf_alpha = held[ALPHA_W-1:0];
      REG_STEP:  cf_step  = held[LIMIT_W-1:0];
      REG_TCHG:  cf_tchg  = held[LIMIT_W-1:0];
      REG_KGAIN: cf_kgain = held[GAIN_REG_W-1:0];
      REG_DGAIN: cf_dgain = held[GAIN_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (torque_replies_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: check every transfer, randomize ready
  initial begin
    reply_t want;
    bit     hold_done;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        if (torque_replies_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, ", $time,
                   "got kind %0d joint %0d torque %0d",
                   out_if.kind, out_if.joint_out, out_if.torque);
        end else begin
          want = torque_replies_q.pop_front();
          if (out_if.kind !== want.kind || out_if.joint_out !== want.jnt ||
              out_if.torque !== want.tq) begin
            errors++;
            $display("%0t: expected kind %0d joint %0d torque %0d, ", $time,
                     want.kind, want.jnt, want.tq,
                     "got kind %0d joint %0d torque %0d",
                     out_if.kind, out_if.joint_out, out_if.torque);
          end
          case (want.kind)
            KIND_TORQUE: n_torque++;
            KIND_ACCEPT: n_accept++;
            default:     n_reject++;
          endcase
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    cmd_t        c;
    reply_t      none_r;
    int          row;
    int          ph;
    int          sent;
    int          k;
    int          n;
    int          r;
    int unsigned jj;
    int unsigned tmp;
    int unsigned order [NJ];
    logic [63:0] v_alpha;
    logic [63:0] v_step;
    logic [63:0] v_tchg;
    logic [63:0] v_kgain;
    logic [63:0] v_dgain;

    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_if.valid    <= 1'b0;
    in_if.mode     <= 1'b0;
    in_if.joint    <= '0;
    in_if.last     <= 1'b0;
    in_if.position <= '0;
    in_if.velocity <= '0;
    in_if.coriolis <= '0;
    none_r = '{KIND_TORQUE, 3'd0, 32'sd0};

    for (k = 0; k < NJ; k++) begin
      jp_meas[k] = '0;
      jp_goal[k] = '0;
      jv_filt[k] = '0;
      jt_prev[k] = '0;
      goal_stage[k] = '0;
    end
    live_mask = '0;
    stage_mask = '0;
    stage_broken = 1'b0;
    cf_alpha = ALPHA_RST;
    cf_step = STEP_RST;
    cf_tchg = TCHG_RST;
    cf_kgain = KGAIN_RST;
    cf_dgain = DGAIN_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < 25; row++)
      push_item(directed_plan[row].cmd, directed_plan[row].fixed, directed_plan[row].reply);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          v_alpha = 64'(ALPHA_ONE);
          v_step  = 64'h7FFF_FFFF;
          v_tchg  = 64'h7FFF_FFFF;
          v_kgain = 64'h7FFF_FFFF_FFFF_FFFF;
          v_dgain = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        1: begin
          v_alpha = '0;
          v_step  = '0;
          v_tchg  = '0;
          v_kgain = '0;
          v_dgain = '0;
        end
        2: begin
          v_alpha = 64'h1_FFFF;
          v_step  = 64'($urandom) & 64'h7FFF_FFFF;
          v_tchg  = 64'($urandom) & 64'h7FFF_FFFF;
          v_kgain = {1'b0, 31'($urandom), 32'($urandom)};
          v_dgain = {1'b0, 31'($urandom), 32'($urandom)};
        end
        default: begin
          v_alpha = 64'($urandom_range(32'h1_FFFF));
          v_step  = 64'($urandom_range(1 << 26));
          v_tchg  = 64'($urandom_range(1 << 22));
          v_kgain = {1'b0, 31'($urandom), 32'($urandom)};
          v_dgain = {1'b0, 31'($urandom), 32'($urandom)};
        end
      endcase
      write_reg(REG_ALPHA, v_alpha);
      write_reg(REG_STEP, v_step);
      write_reg(REG_TCHG, v_tchg);
      write_reg(REG_KGAIN, v_kgain);
      write_reg(REG_DGAIN, v_dgain);

      case (ph % 4)
        0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin src_idle_pct = 68; rcv_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rcv_stall_pct = 68; end
        default: begin src_idle_pct = 23; rcv_stall_pct = 23; end
      endcase
      if (ph == 2) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 55) begin
          c.mode = 1'b1;
          c.jnt  = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(NJ - 1));
          c.last = 1'($urandom_range(1));
          if ($urandom_range(3) == 0)
            c.pos = $urandom;
          else
            c.pos = jp_meas[c.jnt % NJ] + int'($urandom_range(65535)) - 32768;
          c.vel = pick_word();
          c.cor = pick_word();
          push_item(c, 1'b0, none_r);
          if (c.jnt < NJ) sent++;
        end else if (r < 85) begin
          // well-formed set in shuffled joint order
          for (k = 0; k < NJ; k++) order[k] = k;
          for (k = NJ - 1; k > 0; k--) begin
            jj = $urandom_range(k);
            tmp = order[k];
            order[k] = order[jj];
            order[jj] = tmp;
          end
          for (k = 0; k < NJ; k++) begin
            c.mode = 1'b0;
            c.jnt  = 3'(order[k]);
            c.last = (k == NJ - 1);
            c.pos  = near_target(order[k]);
            c.vel  = $urandom;
            c.cor  = $urandom;
            push_item(c, 1'b0, none_r);
            sent++;
          end
        end else if (r < 95) begin
          // short or poisoned set
          n = $urandom_range(NJ, 1);
          for (k = 0; k < n; k++) begin
            c.mode = 1'b0;
            c.jnt  = 3'($urandom_range(7));
            c.last = (k == n - 1);
            c.pos  = near_target(c.jnt % NJ);
            c.vel  = $urandom;
            c.cor  = $urandom;
            push_item(c, 1'b0, none_r);
            sent++;
          end
        end else begin
          c.mode = 1'b0;
          c.jnt  = 3'($urandom_range(7));
          c.last = 1'($urandom_range(1));
          c.pos  = $urandom;
          c.vel  = $urandom;
          c.cor  = $urandom;
          push_item(c, 1'b0, none_r);
          sent++;
        end
      end
    end

    rcv_stall_pct = 0;
    settle();
    $display("covered %0d config phases with idle, stall and long hold-off on the result side",
             PHASES);
    $display("checked %0d torque results, %0d target sets accepted, %0d rejected",
             n_torque, n_accept, n_reject);
    if (errors == 0 && cfg_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/jitc_pkg.sv
rtl/jitc_if.sv
rtl/jitc_ram.sv
rtl/joint_impedance_torque_controller.sv
verif/tb_top.sv
